// File: rtl/bcpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcpe_pkg;

    // Default geometry
    localparam int COORD_WIDTH_DEF     = 16;
    localparam int PARAM_FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int TIME_W    = 16;
    localparam int SPAN_W    = 15;
    localparam int POINT_W   = 48;
    localparam int MODE_W    = 2;
    localparam int NUM_PTS   = 4;
    localparam int NUM_AXES  = 3;

    // Extra bits on a weight above the fraction (headroom for 2x and 3x terms)
    localparam int WGT_EXTRA = 2;

    // Register port
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int APB_IDX_LO = 3;

    // Curve degree; the unused code 3 evaluates as cubic
    typedef enum logic [MODE_W-1:0] {
        MODE_LINEAR = 2'd0,
        MODE_QUAD   = 2'd1,
        MODE_CUBIC  = 2'd2
    } curve_mode_t;

    // Register indexes
    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_POINT0 = 3'd1,
        REG_POINT1 = 3'd2,
        REG_POINT2 = 3'd3,
        REG_POINT3 = 3'd4,
        REG_SPAN   = 3'd5
    } reg_idx_t;

    // Configuration seen by the datapath; span is never zero here
    typedef struct packed {
        curve_mode_t                      mode;
        logic [NUM_PTS-1:0][POINT_W-1:0]  points;
        logic [SPAN_W-1:0]                span;
    } cfg_t;

endpackage

`default_nettype wire

// File: rtl/bcpe_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module bcpe_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bcpe_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [bcpe_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [bcpe_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output bcpe_pkg::cfg_t                       cfg
);

    localparam int DW = bcpe_pkg::APB_DATA_W;
    localparam int PW = bcpe_pkg::POINT_W;
    localparam int SW = bcpe_pkg::SPAN_W;

    bcpe_pkg::curve_mode_t                                      mode_reg;
    logic [bcpe_pkg::NUM_PTS-1:0][PW-1:0]                       point_reg;
    logic [SW-1:0]                                              span_reg;
    bcpe_pkg::reg_idx_t                                         idx;
    logic                                                       wr_en;

    assign pready = 1'b1;
    assign idx    = bcpe_pkg::reg_idx_t'(paddr[bcpe_pkg::APB_ADDR_W-1:bcpe_pkg::APB_IDX_LO]);
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= bcpe_pkg::MODE_LINEAR;
            point_reg <= '0;
            span_reg  <= SW'(1);
        end
        else if (wr_en)
        begin
            unique case (idx)
                bcpe_pkg::REG_MODE:
                    mode_reg <= bcpe_pkg::curve_mode_t'(pwdata[bcpe_pkg::MODE_W-1:0]);
                bcpe_pkg::REG_POINT0: point_reg[0] <= pwdata[PW-1:0];
                bcpe_pkg::REG_POINT1: point_reg[1] <= pwdata[PW-1:0];
                bcpe_pkg::REG_POINT2: point_reg[2] <= pwdata[PW-1:0];
                bcpe_pkg::REG_POINT3: point_reg[3] <= pwdata[PW-1:0];
                bcpe_pkg::REG_SPAN:   span_reg     <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            bcpe_pkg::REG_MODE:   prdata = DW'(mode_reg);
            bcpe_pkg::REG_POINT0: prdata = DW'(point_reg[0]);
            bcpe_pkg::REG_POINT1: prdata = DW'(point_reg[1]);
            bcpe_pkg::REG_POINT2: prdata = DW'(point_reg[2]);
            bcpe_pkg::REG_POINT3: prdata = DW'(point_reg[3]);
            bcpe_pkg::REG_SPAN:   prdata = DW'(span_reg);
            default:              prdata = '0;
        endcase
    end

    // A zero duration acts as one tick
    always_comb
    begin
        cfg.mode   = mode_reg;
        cfg.points = point_reg;
        cfg.span   = (span_reg == '0) ? SW'(1) : span_reg;
    end

endmodule

`default_nettype wire

// File: rtl/bcpe_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Time-to-parameter divider: one quotient bit per stage, then clamp to 1.0
module bcpe_div #(
    parameter int PARAM_FRAC_BITS = bcpe_pkg::PARAM_FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [bcpe_pkg::SPAN_W-1:0]   span,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bcpe_pkg::TIME_W-1:0]   in_time,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [PARAM_FRAC_BITS:0]           out_u
);

    localparam int F  = PARAM_FRAC_BITS;
    localparam int TW = bcpe_pkg::TIME_W;
    localparam int SW = bcpe_pkg::SPAN_W;
    localparam int NW = TW + F;
    localparam int S  = NW + 2;
    localparam logic [F:0] ONE_U = (F + 1)'(1) << F;

    logic [S-1:0]    vld_reg;
    logic [S-1:0]    vld_in;
    logic [S:0]      rdy;

    logic [NW-1:0]   num_reg [NW+1];
    logic [SW-1:0]   rem_reg [NW+1];
    logic [F:0]      q_reg   [NW+1];
    logic            ovf_reg [NW+1];
    logic [F:0]      u_reg;

    logic            tpos;
    logic [NW-1:0]   num0;

    // Ready chain: a stage takes new data when empty or when it moves on
    assign rdy[S] = out_ready;
    for (genvar gi = 0; gi < S; gi++)
    begin : g_rdy
        assign rdy[gi] = !vld_reg[gi] || rdy[gi + 1];
    end

    assign vld_in   = {vld_reg[S-2:0], in_valid};
    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < S; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    // Numerator t * 2^F + span/2; a time at or below zero gives zero
    assign tpos = (in_time != '0) && !in_time[TW-1];
    assign num0 = tpos ? ((NW'(in_time[TW-2:0]) << F) + NW'(span[SW-1:1])) : '0;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            num_reg[0] <= num0;
            rem_reg[0] <= '0;
            q_reg[0]   <= '0;
            ovf_reg[0] <= 1'b0;
        end
    end

    // Restoring division, one numerator bit per stage
    for (genvar gi = 1; gi <= NW; gi++)
    begin : g_step
        logic [SW:0] trial;
        logic        ge;

        assign trial = {rem_reg[gi-1], num_reg[gi-1][NW-1]};
        assign ge    = trial >= {1'b0, span};

        always_ff @(posedge clk)
        begin
            if (rdy[gi])
            begin
                num_reg[gi] <= {num_reg[gi-1][NW-2:0], 1'b0};
                rem_reg[gi] <= ge ? SW'(trial - {1'b0, span}) : trial[SW-1:0];
                q_reg[gi]   <= {q_reg[gi-1][F-1:0], ge};
                ovf_reg[gi] <= ovf_reg[gi-1] | q_reg[gi-1][F];
            end
        end
    end

    // Clamp the quotient to 1.0
    always_ff @(posedge clk)
    begin
        if (rdy[S-1])
        begin
            u_reg <= (ovf_reg[NW] || (q_reg[NW][F] && (|q_reg[NW][F-1:0])))
                     ? ONE_U : q_reg[NW];
        end
    end

    assign out_valid = vld_reg[S-1];
    assign out_u     = u_reg;

endmodule

`default_nettype wire

// File: rtl/bcpe_wgt.sv
`timescale 1ns / 1ps
`default_nettype none

// Bernstein weights of the selected degree
module bcpe_wgt #(
    parameter int PARAM_FRAC_BITS = bcpe_pkg::PARAM_FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bcpe_pkg::curve_mode_t        mode,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [PARAM_FRAC_BITS:0]     in_u,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [bcpe_pkg::NUM_PTS-1:0][PARAM_FRAC_BITS+bcpe_pkg::WGT_EXTRA-1:0] out_w
);

    localparam int F   = PARAM_FRAC_BITS;
    localparam int WW  = F + bcpe_pkg::WGT_EXTRA;
    localparam int PRW = 2 * F + 2;
    localparam int S   = 4;
    localparam logic [F:0]     ONE_U  = (F + 1)'(1) << F;
    localparam logic [PRW-1:0] HALF_P = PRW'(1) << (F - 1);

    logic [S-1:0]  vld_reg;
    logic [S-1:0]  vld_in;
    logic [S:0]    rdy;

    // Stage 0: raw squares and cross product
    logic [F:0]      v0;
    logic [F:0]      u0_reg, v0_reg;
    logic [PRW-1:0]  vvp_reg, uup_reg, uvp_reg;
    // Stage 1: rounded second-order terms
    logic [PRW-1:0]  vvs, uus, uvs;
    logic [F:0]      u1_reg, v1_reg, vv1_reg, uu1_reg, uv1_reg;
    // Stage 2: raw cubic products
    logic [F:0]      u2_reg, v2_reg, vv2_reg, uu2_reg, uv2_reg;
    logic [PRW-1:0]  c0_reg, c1_reg, c2_reg, c3_reg;
    // Stage 3: rounded, scaled and selected weights
    logic [PRW-1:0]  c0s, c1s, c2s, c3s;
    logic [F:0]      rc0, rc1, rc2, rc3;
    logic [bcpe_pkg::NUM_PTS-1:0][WW-1:0] w_next, w_reg;

    assign rdy[S] = out_ready;
    for (genvar gi = 0; gi < S; gi++)
    begin : g_rdy
        assign rdy[gi] = !vld_reg[gi] || rdy[gi + 1];
    end

    assign vld_in   = {vld_reg[S-2:0], in_valid};
    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < S; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    // Stage 0: v = 1 - u, then squares
    assign v0 = ONE_U - in_u;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            u0_reg  <= in_u;
            v0_reg  <= v0;
            vvp_reg <= PRW'(v0) * PRW'(v0);
            uup_reg <= PRW'(in_u) * PRW'(in_u);
            uvp_reg <= PRW'(in_u) * PRW'(v0);
        end
    end

    // Stage 1: round to nearest
    assign vvs = vvp_reg + HALF_P;
    assign uus = uup_reg + HALF_P;
    assign uvs = uvp_reg + HALF_P;

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            u1_reg  <= u0_reg;
            v1_reg  <= v0_reg;
            vv1_reg <= vvs[2*F:F];
            uu1_reg <= uus[2*F:F];
            uv1_reg <= uvs[2*F:F];
        end
    end

    // Stage 2: cubic products
    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            u2_reg  <= u1_reg;
            v2_reg  <= v1_reg;
            vv2_reg <= vv1_reg;
            uu2_reg <= uu1_reg;
            uv2_reg <= uv1_reg;
            c0_reg  <= PRW'(vv1_reg) * PRW'(v1_reg);
            c1_reg  <= PRW'(vv1_reg) * PRW'(u1_reg);
            c2_reg  <= PRW'(uu1_reg) * PRW'(v1_reg);
            c3_reg  <= PRW'(uu1_reg) * PRW'(u1_reg);
        end
    end

    // Stage 3: round cubic terms and pick the weights of the degree
    assign c0s = c0_reg + HALF_P;
    assign c1s = c1_reg + HALF_P;
    assign c2s = c2_reg + HALF_P;
    assign c3s = c3_reg + HALF_P;
    assign rc0 = c0s[2*F:F];
    assign rc1 = c1s[2*F:F];
    assign rc2 = c2s[2*F:F];
    assign rc3 = c3s[2*F:F];

    always_comb
    begin
        case (mode)
            bcpe_pkg::MODE_LINEAR:
            begin
                w_next[0] = WW'(v2_reg);
                w_next[1] = WW'(u2_reg);
                w_next[2] = '0;
                w_next[3] = '0;
            end
            bcpe_pkg::MODE_QUAD:
            begin
                w_next[0] = WW'(vv2_reg);
                w_next[1] = WW'({uv2_reg, 1'b0});
                w_next[2] = WW'(uu2_reg);
                w_next[3] = '0;
            end
            default:
            begin
                w_next[0] = WW'(rc0);
                w_next[1] = WW'({rc1, 1'b0}) + WW'(rc1);
                w_next[2] = WW'({rc2, 1'b0}) + WW'(rc2);
                w_next[3] = WW'(rc3);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            w_reg <= w_next;
        end
    end

    assign out_valid = vld_reg[S-1];
    assign out_w     = w_reg;

endmodule

`default_nettype wire

// File: rtl/bcpe_acc.sv
`timescale 1ns / 1ps
`default_nettype none

// Weighted sum per axis, round to nearest and saturate
module bcpe_acc #(
    parameter int COORD_WIDTH     = bcpe_pkg::COORD_WIDTH_DEF,
    parameter int PARAM_FRAC_BITS = bcpe_pkg::PARAM_FRAC_BITS_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic [bcpe_pkg::NUM_PTS-1:0][bcpe_pkg::POINT_W-1:0] points,
    input  wire logic                                        in_valid,
    output logic                                             in_ready,
    input  wire logic [bcpe_pkg::NUM_PTS-1:0][PARAM_FRAC_BITS+bcpe_pkg::WGT_EXTRA-1:0] in_w,
    output logic                                             out_valid,
    input  wire logic                                        out_ready,
    output logic [bcpe_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]   out_pos
);

    localparam int C   = COORD_WIDTH;
    localparam int F   = PARAM_FRAC_BITS;
    localparam int WW  = F + bcpe_pkg::WGT_EXTRA;
    localparam int PW  = WW + 1 + C;
    localparam int SW  = PW + 2;
    localparam int NP  = bcpe_pkg::NUM_PTS;
    localparam int NA  = bcpe_pkg::NUM_AXES;
    localparam int PE  = (3 * C > bcpe_pkg::POINT_W) ? 3 * C : bcpe_pkg::POINT_W;
    localparam int S   = 3;
    localparam logic [SW-1:0] HALF_S  = SW'(1) << (F - 1);
    localparam logic [C-1:0]  POS_MAX = {1'b0, {(C - 1){1'b1}}};
    localparam logic [C-1:0]  NEG_MIN = {1'b1, {(C - 1){1'b0}}};

    logic [S-1:0]  vld_reg;
    logic [S-1:0]  vld_in;
    logic [S:0]    rdy;

    logic signed [PW-1:0]  prod_reg [NP][NA];
    logic signed [SW-1:0]  s01_reg  [NA];
    logic signed [SW-1:0]  s23_reg  [NA];
    logic [NA-1:0][C-1:0]  pos_reg;

    assign rdy[S] = out_ready;
    for (genvar gi = 0; gi < S; gi++)
    begin : g_rdy
        assign rdy[gi] = !vld_reg[gi] || rdy[gi + 1];
    end

    assign vld_in   = {vld_reg[S-2:0], in_valid};
    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < S; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    // Stage 0: one product per point and axis
    for (genvar gk = 0; gk < NP; gk++)
    begin : g_pt
        logic [PE-1:0]        ext;
        logic signed [WW:0]   ws;

        assign ext = PE'(points[gk]);
        assign ws  = $signed({1'b0, in_w[gk]});

        for (genvar ga = 0; ga < NA; ga++)
        begin : g_ax
            logic signed [C-1:0] cs;

            assign cs = $signed(ext[ga*C +: C]);

            always_ff @(posedge clk)
            begin
                if (rdy[0])
                begin
                    prod_reg[gk][ga] <= PW'(ws) * PW'(cs);
                end
            end
        end
    end

    for (genvar ga = 0; ga < NA; ga++)
    begin : g_sum
        logic signed [SW-1:0] tot;
        logic signed [SW-1:0] shr;
        logic                 fits;

        // Stage 1: pair sums, rounding offset folded in
        always_ff @(posedge clk)
        begin
            if (rdy[1])
            begin
                s01_reg[ga] <= SW'(prod_reg[0][ga]) + SW'(prod_reg[1][ga]) + $signed(HALF_S);
                s23_reg[ga] <= SW'(prod_reg[2][ga]) + SW'(prod_reg[3][ga]);
            end
        end

        // Stage 2: total, floor shift and saturate
        assign tot  = s01_reg[ga] + s23_reg[ga];
        assign shr  = tot >>> F;
        assign fits = (&shr[SW-1:C-1]) || !(|shr[SW-1:C-1]);

        always_ff @(posedge clk)
        begin
            if (rdy[2])
            begin
                pos_reg[ga] <= fits ? shr[C-1:0] : (shr[SW-1] ? NEG_MIN : POS_MAX);
            end
        end
    end

    assign out_valid = vld_reg[S-1];
    assign out_pos   = pos_reg;

endmodule

`default_nettype wire

// File: rtl/bezier_curve_point_eval_top.sv
// Cubic/quadratic/linear Bezier point evaluator, three axes.
// Slave stream: s_tdata carries one signed time in ticks per item. Master
// stream: m_tdata carries the curve point (x, y, z), signed fixed point.
// The APB port holds curve mode, four control points and the duration;
// write it only while no item is in flight. pready is tied high.
// The time divider has a numerator stage, then resolves one quotient bit
// per stage over 16 + PARAM_FRAC_BITS stages, then a clamp stage; four
// weight stages and three multiply-accumulate stages follow.
// Throughput is one item per cycle unless the output stalls; every
// stage carries a valid bit.
// When m_tready is low the output holds its item and upstream stages keep
// filling any empty slots; s_tready drops only once every stage is full.
// Nothing is lost or repeated across a stall.
// Reset clears all valid bits and sets linear mode, zero points and a
// duration of one tick.
`timescale 1ns / 1ps
`default_nettype none

module bezier_curve_point_eval_top #(
    parameter int COORD_WIDTH     = bcpe_pkg::COORD_WIDTH_DEF,
    parameter int PARAM_FRAC_BITS = bcpe_pkg::PARAM_FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Slave stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bcpe_pkg::TIME_W-1:0]     s_tdata,   // time_tick
    // Master stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]   m_tdata,   // pos_x, pos_y, pos_z
    // Register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bcpe_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [bcpe_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [bcpe_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    localparam int F  = PARAM_FRAC_BITS;
    localparam int WW = F + bcpe_pkg::WGT_EXTRA;
    localparam int OW = ((3 * COORD_WIDTH + 7) / 8) * 8;

    bcpe_pkg::cfg_t                                   cfg;
    logic                                             div_valid, div_ready;
    logic [F:0]                                       div_u;
    logic                                             wgt_valid, wgt_ready;
    logic [bcpe_pkg::NUM_PTS-1:0][WW-1:0]             wgt_w;
    logic [bcpe_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]   pos;

    bcpe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcpe_div #(
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .span      (cfg.span),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_time   (s_tdata),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_u     (div_u)
    );

    bcpe_wgt #(
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_wgt (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (cfg.mode),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_u      (div_u),
        .out_valid (wgt_valid),
        .out_ready (wgt_ready),
        .out_w     (wgt_w)
    );

    bcpe_acc #(
        .COORD_WIDTH     (COORD_WIDTH),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .points    (cfg.points),
        .in_valid  (wgt_valid),
        .in_ready  (wgt_ready),
        .in_w      (wgt_w),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pos   (pos)
    );

    // Pack x in the low bits, then y, then z
    assign m_tdata = OW'(pos);

endmodule

`default_nettype wire

// File: tb/sv/bezier_curve_point_eval_top_tb.sv
`timescale 1ns / 1ps

module bezier_curve_point_eval_top_tb;

    localparam int CW    = bcpe_pkg::COORD_WIDTH_DEF;
    localparam int FRAC  = bcpe_pkg::PARAM_FRAC_BITS_DEF;
    localparam int OUT_W = ((3 * CW + 7) / 8) * 8;
    localparam longint unsigned ONE_U  = 64'd1 << FRAC;
    localparam longint unsigned HALF_U = 64'd1 << (FRAC - 1);
    localparam longint HALF_S = longint'(HALF_U);
    localparam longint COORD_MIN = -(longint'(1) << (CW - 1));
    localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
    // Unused mode code; evaluates as cubic
    localparam logic [bcpe_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [CW-1:0] C_NEG = {1'b1, {(CW - 1){1'b0}}};
    localparam logic [CW-1:0] C_POS = {1'b0, {(CW - 1){1'b1}}};

    typedef struct packed {
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
    } point_t;

    logic                                clk      = 1'b0;
    logic                                rst_n    = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [bcpe_pkg::TIME_W-1:0]         s_tdata  = '0;    // time_tick
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [OUT_W-1:0]                    m_tdata;          // pos_x, pos_y, pos_z
    logic                                psel     = 1'b0;
    logic                                penable  = 1'b0;
    logic                                pwrite   = 1'b0;
    logic [bcpe_pkg::APB_ADDR_W-1:0]     paddr    = '0;
    logic [bcpe_pkg::APB_DATA_W-1:0]     pwdata   = '0;
    logic [bcpe_pkg::APB_DATA_W-1:0]     prdata;
    logic                                pready;

    // Shadow of the register file
    logic [bcpe_pkg::MODE_W-1:0]         cfg_mode = bcpe_pkg::MODE_LINEAR;
    logic [bcpe_pkg::POINT_W-1:0]        cfg_pts[bcpe_pkg::NUM_PTS] = '{default: '0};
    logic [bcpe_pkg::SPAN_W-1:0]         cfg_span = 1;

    logic [bcpe_pkg::TIME_W-1:0]         time_pending[$];
    point_t                              pos_expected[$];
    int                                  mismatch_count = 0;
    int                                  burst_left = 1;
    int                                  gap_left = 0;
    int                                  rx_mode = 0;
    int                                  rx_left = 0;

    bezier_curve_point_eval_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic longint unsigned round_frac(input longint unsigned a);
        return (a + HALF_U) >> FRAC;
    endfunction

    // Evaluate the curve point for one time value under the shadow config
    function automatic point_t curve_point_at(input logic [bcpe_pkg::TIME_W-1:0] t);
        longint unsigned span;
        longint unsigned u;
        longint unsigned v;
        longint unsigned vv;
        longint unsigned uu;
        longint unsigned wgt[bcpe_pkg::NUM_PTS];
        int              n_pts;
        longint          acc;
        logic signed [CW-1:0] c;
        point_t          res;
        span = (cfg_span == 0) ? 64'd1 : {49'd0, cfg_span};
        u = 0;
        wgt = '{default: 0};
        if (!t[bcpe_pkg::TIME_W-1] && t != 0)
        begin
            u = {48'd0, t};
            u = ((u << FRAC) + (span >> 1)) / span;
            if (u > ONE_U)
                u = ONE_U;
        end
        v = ONE_U - u;
        case (cfg_mode)
            bcpe_pkg::MODE_LINEAR:
            begin
                n_pts = 2;
                wgt[0] = v;
                wgt[1] = u;
            end
            bcpe_pkg::MODE_QUAD:
            begin
                n_pts = 3;
                wgt[0] = round_frac(v * v);
                wgt[1] = 2 * round_frac(u * v);
                wgt[2] = round_frac(u * u);
            end
            default:
            begin
                n_pts = 4;
                vv = round_frac(v * v);
                uu = round_frac(u * u);
                wgt[0] = round_frac(vv * v);
                wgt[1] = 3 * round_frac(vv * u);
                wgt[2] = 3 * round_frac(uu * v);
                wgt[3] = round_frac(uu * u);
            end
        endcase
        for (int axis = 0; axis < bcpe_pkg::NUM_AXES; axis++)
        begin
            acc = 0;
            for (int k = 0; k < n_pts; k++)
            begin
                c = cfg_pts[k][CW*axis +: CW];
                acc += longint'(wgt[k]) * longint'(c);
            end
            acc = (acc + HALF_S) >>> FRAC;
            if (acc < COORD_MIN)
                acc = COORD_MIN;
            if (acc > COORD_MAX)
                acc = COORD_MAX;
            res[CW*axis +: CW] = acc[CW-1:0];
        end
        return res;
    endfunction

    // Write one register through an APB setup phase and an access phase
    task automatic reg_write(input bcpe_pkg::reg_idx_t idx,
                             input logic [bcpe_pkg::APB_DATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bcpe_pkg::REG_MODE: cfg_mode = val[bcpe_pkg::MODE_W-1:0];
            bcpe_pkg::REG_SPAN: cfg_span = val[bcpe_pkg::SPAN_W-1:0];
            default:            cfg_pts[idx - bcpe_pkg::REG_POINT0] = val[bcpe_pkg::POINT_W-1:0];
        endcase
    endtask

    // Wait until every queued item has gone in and every result has come back
    task automatic drain();
        @(negedge clk);
        while (time_pending.size() != 0 || pos_expected.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return C_NEG;
            1:       return C_POS;
            default: return CW'($urandom);
        endcase
    endfunction

    // Random point with junk above the point field
    function automatic logic [bcpe_pkg::APB_DATA_W-1:0] rand_point_word();
        logic [bcpe_pkg::APB_DATA_W-1:0] w;
        w = {$urandom, $urandom};
        w[bcpe_pkg::POINT_W-1:0] = {rand_coord(), rand_coord(), rand_coord()};
        return w;
    endfunction

    function automatic logic [bcpe_pkg::SPAN_W-1:0] rand_span();
        case ($urandom_range(0, 6))
            0:       return bcpe_pkg::SPAN_W'($urandom_range(1, 8));
            1:       return bcpe_pkg::SPAN_W'($urandom_range(9, 300));
            2:       return bcpe_pkg::SPAN_W'($urandom_range(301, 4000));
            3:       return '1;
            4:       return '0;
            default: return bcpe_pkg::SPAN_W'($urandom_range(1, 32767));
        endcase
    endfunction

    // Mostly times on the curve, some near its ends, some anywhere
    function automatic logic [bcpe_pkg::TIME_W-1:0] rand_time(input int span);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return bcpe_pkg::TIME_W'($urandom_range(0, span));
            6:                return bcpe_pkg::TIME_W'(span + $urandom_range(0, 6) - 3);
            7:                return bcpe_pkg::TIME_W'($urandom_range(0, 6) - 3);
            8:                return bcpe_pkg::TIME_W'($urandom);
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    // Driver: bursts of items with random gaps, hold while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            burst_left = 1;
            gap_left   = 0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            if (s_tvalid)
            begin
                pos_expected.push_back(curve_point_at(s_tdata));
                void'(time_pending.pop_front());
            end
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (time_pending.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= time_pending[0];
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: switch between stall patterns every so often
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_mode = 0;
            rx_left = 0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            else
                rx_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) == 0);
                2:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ((rx_left % 16) < 4);
            endcase
        end
    end

    task automatic check_coord(input string name, input logic signed [CW-1:0] want,
                               input logic signed [CW-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        point_t want;
        point_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[3*CW-1:0];
            if (pos_expected.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, actual x=%0d y=%0d z=%0d",
                         $time, got.x, got.y, got.z);
            end
            else
            begin
                want = pos_expected.pop_front();
                check_coord("pos_x", want.x, got.x);
                check_coord("pos_y", want.y, got.y);
                check_coord("pos_z", want.z, got.z);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("bezier_curve_point_eval_top regression: fail");
        $finish;
    end

    initial
    begin
        int span_eff;
        int n_items;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset configuration: linear, zero points, one-tick span
        @(negedge clk);
        time_pending.push_back(16'h8000);
        time_pending.push_back(16'h7FFF);
        drain();

        // Cubic with alternating extreme points
        reg_write(bcpe_pkg::REG_MODE, {62'd0, bcpe_pkg::MODE_CUBIC});
        reg_write(bcpe_pkg::REG_POINT0, {16'hFFFF, C_NEG, C_NEG, C_NEG});
        reg_write(bcpe_pkg::REG_POINT1, {16'h0000, C_POS, C_POS, C_POS});
        reg_write(bcpe_pkg::REG_POINT2, {16'hA5A5, C_NEG, C_POS, C_NEG});
        reg_write(bcpe_pkg::REG_POINT3, {16'h0000, C_POS, C_NEG, C_POS});
        reg_write(bcpe_pkg::REG_SPAN, 64'd100);
        @(negedge clk);
        time_pending.push_back(16'd0);
        time_pending.push_back(16'd1);
        time_pending.push_back(16'd50);
        time_pending.push_back(16'd99);
        time_pending.push_back(16'd100);
        time_pending.push_back(16'd101);
        time_pending.push_back(16'h7FFF);
        time_pending.push_back(16'hFFFF);
        time_pending.push_back(16'h8000);
        drain();

        // Spare mode code falls back to cubic
        reg_write(bcpe_pkg::REG_MODE, {62'd0, MODE_SPARE});
        @(negedge clk);
        time_pending.push_back(16'd33);
        time_pending.push_back(16'd67);
        drain();

        // Quadratic with a zero span, which counts as one tick
        reg_write(bcpe_pkg::REG_MODE, {62'd0, bcpe_pkg::MODE_QUAD});
        reg_write(bcpe_pkg::REG_SPAN, 64'd0);
        @(negedge clk);
        time_pending.push_back(16'd0);
        time_pending.push_back(16'd1);
        time_pending.push_back(16'hFFFF);
        drain();

        // Linear over the longest span
        reg_write(bcpe_pkg::REG_MODE, {62'd0, bcpe_pkg::MODE_LINEAR});
        reg_write(bcpe_pkg::REG_SPAN, 64'd32767);
        @(negedge clk);
        time_pending.push_back(16'd1);
        time_pending.push_back(16'd16383);
        time_pending.push_back(16'd16384);
        time_pending.push_back(16'h7FFF);
        drain();

        // Random phases; each ends with a full drain before reconfiguring
        for (int ph = 0; ph < 8; ph++)
        begin
            reg_write(bcpe_pkg::REG_MODE, {$urandom, 30'd0, 2'($urandom_range(0, 3))});
            reg_write(bcpe_pkg::REG_POINT0, rand_point_word());
            reg_write(bcpe_pkg::REG_POINT1, rand_point_word());
            reg_write(bcpe_pkg::REG_POINT2, rand_point_word());
            reg_write(bcpe_pkg::REG_POINT3, rand_point_word());
            reg_write(bcpe_pkg::REG_SPAN, {$urandom, 17'($urandom), rand_span()});
            span_eff = (cfg_span == 0) ? 1 : int'(cfg_span);
            n_items = $urandom_range(50, 75);
            @(negedge clk);
            for (int i = 0; i < n_items; i++)
                time_pending.push_back(rand_time(span_eff));
            drain();
        end

        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("bezier_curve_point_eval_top regression: pass");
        else
            $display("bezier_curve_point_eval_top regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/bcpe_pkg.sv
rtl/bcpe_regs.sv
rtl/bcpe_div.sv
rtl/bcpe_wgt.sv
rtl/bcpe_acc.sv
rtl/bezier_curve_point_eval_top.sv
tb/sv/bezier_curve_point_eval_top_tb.sv
